FILE: src/sample_trim_nudge_core_defines.svh
// ----------------------------------------------------------------------------
// Sample trim nudge assertion macros
// Shared property wrappers for the checker; clk and rst_n come from the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_TRIM_NUDGE_CORE_DEFINES_SVH
`define SAMPLE_TRIM_NUDGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stn_pkg.sv
// ----------------------------------------------------------------------------
// Sample trim nudge package
// Widths, constants and payload types shared by the trim nudge pipeline.
// ----------------------------------------------------------------------------
package stn_pkg;

  localparam int BYTE_COUNT_WIDTH = 32;
  localparam int BC_W             = BYTE_COUNT_WIDTH;
  localparam int FIELD_W          = 32;
  localparam int FINE_W           = 13;
  localparam int RATE_W           = 18;
  localparam int ALIGN_W          = 4;
  localparam int MIN_W            = 16;
  localparam int MAG_W            = FINE_W;
  localparam int SQ_W             = 2 * MAG_W;
  localparam int FR_W             = RATE_W + ALIGN_W;
  localparam int RATE_STEP_SHIFT  = 12;
  localparam int SIZE_STEP_SHIFT  = 14;
  localparam int STEP_W           = (FR_W - RATE_STEP_SHIFT > BC_W - SIZE_STEP_SHIFT) ?
                                    (FR_W - RATE_STEP_SHIFT) : (BC_W - SIZE_STEP_SHIFT);
  localparam int DELTA_W          = STEP_W + SQ_W;
  localparam int RAW_W            = ((DELTA_W > BC_W) ? DELTA_W : BC_W) + 1;
  localparam int CMP_W            = (BC_W > FR_W) ? BC_W : FR_W;

  localparam int REM_BITS         = 8;
  localparam int REM_STAGES       = (BC_W + REM_BITS - 1) / REM_BITS;
  localparam int PAD_W            = REM_STAGES * REM_BITS;

  localparam int FRONT_STAGES     = 3;
  localparam int CLAMP_STAGES     = 2;
  localparam int TAIL_STAGES      = 3;
  localparam int LATENCY          = FRONT_STAGES + CLAMP_STAGES + REM_STAGES + TAIL_STAGES;

  localparam int IN_FIELDS_W      = FINE_W + RATE_W + ALIGN_W + 4 * FIELD_W;
  localparam int IN_TDATA_W       = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W      = 3 * FIELD_W;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [MIN_W-1:0] RESET_MIN_TRIM = MIN_W'(4412);
  localparam logic [BC_W-1:0]  LARGE_SAMPLE   = BC_W'(32768);

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_SIZE    = 1'b1;
  localparam logic REG_MIN_TRIM = 1'b0;

  typedef logic [BC_W-1:0]    bc_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [ALIGN_W-1:0] align_t;

  typedef struct packed {
    logic              mode;
    logic [FINE_W-1:0] fine;
    bc_t               total_bytes;
    logic [RATE_W-1:0] rate_hz;
    align_t            align_bytes;
    bc_t               start_in;
    bc_t               size_in;
    bc_t               end_in;
  } item_t;

  typedef struct packed {
    logic   mode;
    logic   neg;
    bc_t    total_bytes;
    bc_t    start_in;
    bc_t    size_in;
    bc_t    end_in;
    align_t align_bytes;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [DELTA_W-1:0] delta;
  } nudge_t;

  typedef struct packed {
    logic   mode;
    bc_t    x;
    bc_t    y;
    bc_t    total_bytes;
    align_t align_bytes;
  } trim_t;

  typedef struct packed {
    field_t end_out;
    field_t size_out;
    field_t start_out;
  } result_t;

endpackage

FILE: src/stn_front.sv
// ----------------------------------------------------------------------------
// Sample trim nudge front end
// Three stages: frame rate and knob square, step selection, displacement.
// ----------------------------------------------------------------------------
module stn_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stn_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output stn_pkg::nudge_t out_item
);
  import stn_pkg::*;

  typedef struct packed {
    ctx_t              ctx;
    logic [FR_W-1:0]   frame_rate;
    logic [SQ_W-1:0]   sq;
  } s1_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [STEP_W-1:0] step;
    logic [SQ_W-1:0]   sq;
  } s2_t;

  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  nudge_t s3_r, s3_nxt;
  logic   v1_r, v2_r, v3_r;
  logic   rdy1, rdy2, rdy3;
  align_t align_eff;
  logic [MAG_W-1:0] mag;

  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3_r;
  assign out_item  = s3_r;

  assign align_eff = (in_item.align_bytes == '0) ? ALIGN_W'(1) : in_item.align_bytes;
  assign mag       = in_item.fine[FINE_W-1] ? (MAG_W'(0) - in_item.fine) : in_item.fine;

  always_comb begin
    s1_nxt.ctx.mode        = in_item.mode;
    s1_nxt.ctx.neg         = in_item.fine[FINE_W-1];
    s1_nxt.ctx.total_bytes = in_item.total_bytes;
    s1_nxt.ctx.start_in    = in_item.start_in;
    s1_nxt.ctx.size_in     = in_item.size_in;
    s1_nxt.ctx.end_in      = in_item.end_in;
    s1_nxt.ctx.align_bytes = align_eff;
    s1_nxt.frame_rate      = FR_W'(in_item.rate_hz) * FR_W'(align_eff);
    s1_nxt.sq              = SQ_W'(mag) * SQ_W'(mag);
  end

  always_comb begin
    s2_nxt.ctx = s1_r.ctx;
    s2_nxt.sq  = s1_r.sq;
    if (CMP_W'(s1_r.ctx.total_bytes) > CMP_W'(s1_r.frame_rate)) begin
      s2_nxt.step = STEP_W'(s1_r.frame_rate >> RATE_STEP_SHIFT);
    end else if (s1_r.ctx.total_bytes >= LARGE_SAMPLE) begin
      s2_nxt.step = STEP_W'(s1_r.ctx.total_bytes >> SIZE_STEP_SHIFT);
    end else begin
      s2_nxt.step = STEP_W'(1);
    end
  end

  always_comb begin
    s3_nxt.ctx   = s2_r.ctx;
    s3_nxt.delta = DELTA_W'(s2_r.step) * DELTA_W'(s2_r.sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

endmodule

FILE: src/stn_clamp.sv
// ----------------------------------------------------------------------------
// Sample trim nudge clamp
// Two stages: move start or size by the displacement, then clamp it.
// ----------------------------------------------------------------------------
module stn_clamp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [stn_pkg::MIN_W-1:0] min_trim,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  stn_pkg::nudge_t           in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output stn_pkg::trim_t            out_item
);
  import stn_pkg::*;

  typedef struct packed {
    logic             mode;
    logic [RAW_W-1:0] raw;
    bc_t              lim;
    bc_t              y;
    bc_t              total_bytes;
    align_t           align_bytes;
  } s4_t;

  s4_t   s4_r, s4_nxt;
  trim_t s5_r, s5_nxt;
  logic  v4_r, v5_r;
  logic  rdy4, rdy5;
  logic  shrink;
  logic [RAW_W-1:0] d, st, sz, mn;

  assign rdy5      = !v5_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v5_r;
  assign out_item  = s5_r;

  assign shrink = in_item.ctx.neg && (in_item.delta != '0);
  assign d      = RAW_W'(in_item.delta);
  assign st     = RAW_W'(in_item.ctx.start_in);
  assign sz     = RAW_W'(in_item.ctx.size_in);
  assign mn     = RAW_W'(min_trim);

  always_comb begin
    s4_nxt.mode        = in_item.ctx.mode;
    s4_nxt.total_bytes = in_item.ctx.total_bytes;
    s4_nxt.align_bytes = in_item.ctx.align_bytes;
    if (in_item.ctx.mode == MODE_SIZE) begin
      s4_nxt.lim = in_item.ctx.total_bytes;
      s4_nxt.y   = in_item.ctx.start_in;
      if (shrink) begin
        s4_nxt.raw = (sz > d + mn) ? (sz - d) : mn;
      end else begin
        s4_nxt.raw = sz + d;
      end
    end else begin
      s4_nxt.lim = in_item.ctx.end_in;
      s4_nxt.y   = in_item.ctx.size_in;
      if (shrink) begin
        s4_nxt.raw = (st > d) ? (st - d) : '0;
      end else begin
        s4_nxt.raw = st + d;
      end
    end
  end

  always_comb begin
    s5_nxt.mode        = s4_r.mode;
    s5_nxt.y           = s4_r.y;
    s5_nxt.total_bytes = s4_r.total_bytes;
    s5_nxt.align_bytes = s4_r.align_bytes;
    s5_nxt.x           = (s4_r.raw > RAW_W'(s4_r.lim)) ? s4_r.lim : BC_W'(s4_r.raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) s4_r <= s4_nxt;
    if (rdy5) s5_r <= s5_nxt;
  end

endmodule

FILE: src/stn_align.sv
// ----------------------------------------------------------------------------
// Sample trim nudge alignment
// Bytewise remainder stages for the moved value, the passed value and the
// sample size, then align down, end clipping and the output register.
// ----------------------------------------------------------------------------
module stn_align (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  stn_pkg::trim_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output stn_pkg::result_t out_item
);
  import stn_pkg::*;

  typedef struct packed {
    logic   mode;
    bc_t    x;
    bc_t    y;
    bc_t    total_bytes;
    align_t align_bytes;
    align_t rx;
    align_t ry;
    align_t rt;
  } rs_t;

  typedef struct packed {
    logic   mode;
    bc_t    s_al;
    bc_t    y;
    bc_t    total_bytes;
    align_t ry;
    align_t rt;
  } t1_t;

  typedef struct packed {
    logic   mode;
    bc_t    s_al;
    bc_t    y;
    bc_t    e;
    align_t re;
  } t2_t;

  function automatic align_t rem_byte(align_t r_in, logic [REM_BITS-1:0] b, align_t a);
    logic [ALIGN_W:0] t;
    align_t           r;
    r = r_in;
    for (int i = REM_BITS - 1; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= {1'b0, a}) t = t - {1'b0, a};
      r = t[ALIGN_W-1:0];
    end
    return r;
  endfunction

  rs_t     src_pl [REM_STAGES];
  logic    src_v  [REM_STAGES];
  rs_t     rs_r   [REM_STAGES];
  rs_t     rs_nxt [REM_STAGES];
  logic    rv_r   [REM_STAGES];
  logic    rrdy   [REM_STAGES+1];
  t1_t     t1_r, t1_nxt;
  t2_t     t2_r, t2_nxt;
  result_t o_r, o_nxt;
  logic    t1v_r, t2v_r, ov_r;
  logic    t1_rdy, t2_rdy, o_rdy;
  logic [BC_W:0] sum;
  logic    clip;

  assign o_rdy            = !ov_r || out_ready;
  assign t2_rdy           = !t2v_r || o_rdy;
  assign t1_rdy           = !t1v_r || t2_rdy;
  assign rrdy[REM_STAGES] = t1_rdy;
  assign in_ready         = rrdy[0];
  assign out_valid        = ov_r;
  assign out_item         = o_r;

  always_comb begin
    src_pl[0].mode        = in_item.mode;
    src_pl[0].x           = in_item.x;
    src_pl[0].y           = in_item.y;
    src_pl[0].total_bytes = in_item.total_bytes;
    src_pl[0].align_bytes = in_item.align_bytes;
    src_pl[0].rx          = '0;
    src_pl[0].ry          = '0;
    src_pl[0].rt          = '0;
    src_v[0]              = in_valid;
  end

  for (genvar k = 0; k < REM_STAGES; k++) begin : g_rem
    localparam int HI = PAD_W - 1 - REM_BITS * k;
    logic [PAD_W-1:0] px, py, pt;

    if (k > 0) begin : g_link
      assign src_pl[k] = rs_r[k-1];
      assign src_v[k]  = rv_r[k-1];
    end

    assign px      = PAD_W'(src_pl[k].x);
    assign py      = PAD_W'(src_pl[k].y);
    assign pt      = PAD_W'(src_pl[k].total_bytes);
    assign rrdy[k] = !rv_r[k] || rrdy[k+1];

    always_comb begin
      rs_nxt[k]    = src_pl[k];
      rs_nxt[k].rx = rem_byte(src_pl[k].rx, px[HI -: REM_BITS], src_pl[k].align_bytes);
      rs_nxt[k].ry = rem_byte(src_pl[k].ry, py[HI -: REM_BITS], src_pl[k].align_bytes);
      rs_nxt[k].rt = rem_byte(src_pl[k].rt, pt[HI -: REM_BITS], src_pl[k].align_bytes);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k] <= 1'b0;
      end else if (rrdy[k]) begin
        rv_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rrdy[k]) rs_r[k] <= rs_nxt[k];
    end
  end

  always_comb begin
    t1_nxt.mode        = rs_r[REM_STAGES-1].mode;
    t1_nxt.s_al        = rs_r[REM_STAGES-1].x - BC_W'(rs_r[REM_STAGES-1].rx);
    t1_nxt.y           = rs_r[REM_STAGES-1].y;
    t1_nxt.total_bytes = rs_r[REM_STAGES-1].total_bytes;
    t1_nxt.ry          = rs_r[REM_STAGES-1].ry;
    t1_nxt.rt          = rs_r[REM_STAGES-1].rt;
  end

  assign sum  = (BC_W+1)'(t1_r.s_al) + (BC_W+1)'(t1_r.y);
  assign clip = sum > (BC_W+1)'(t1_r.total_bytes);

  always_comb begin
    t2_nxt.mode = t1_r.mode;
    t2_nxt.s_al = t1_r.s_al;
    t2_nxt.y    = t1_r.y;
    t2_nxt.e    = clip ? t1_r.total_bytes : BC_W'(sum);
    t2_nxt.re   = clip ? t1_r.rt : t1_r.ry;
  end

  always_comb begin
    o_nxt.end_out = FIELD_W'(t2_r.e - BC_W'(t2_r.re));
    if (t2_r.mode == MODE_SIZE) begin
      o_nxt.start_out = FIELD_W'(t2_r.y);
      o_nxt.size_out  = FIELD_W'(t2_r.s_al);
    end else begin
      o_nxt.start_out = FIELD_W'(t2_r.s_al);
      o_nxt.size_out  = FIELD_W'(t2_r.y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1v_r <= 1'b0;
      t2v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (t1_rdy) t1v_r <= rv_r[REM_STAGES-1];
      if (t2_rdy) t2v_r <= t1v_r;
      if (o_rdy)  ov_r  <= t2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t1_rdy) t1_r <= t1_nxt;
    if (t2_rdy) t2_r <= t2_nxt;
    if (o_rdy)  o_r  <= o_nxt;
  end

endmodule

FILE: src/sample_trim_nudge_core.sv
// ----------------------------------------------------------------------------
// Sample trim nudge core
// One knob nudge moves the trim start or size of a sample, with the trim end
// following, all aligned down to the frame size.
// ----------------------------------------------------------------------------
// Each input beat carries a nudge and the current trim window: mode on
// in_tuser, the other fields packed in in_tdata. Each input beat gives exactly
// one output beat with the new start, size and end on out_tdata, in order.
// The pipeline takes one beat per cycle unless a stalled receiver has filled
// every stage. Each beat passes through three front stages (two multipliers,
// step select, displacement multiply), two clamp stages, one remainder stage
// per byte of the byte count, and three stages for align, end clip and output.
// Every stage holds its own valid bit, so a stalled receiver only stops the
// stages that are full; bubbles close up and in_tready stays high until every
// stage holds a beat, after which it follows out_tready.
// min_trim_size sits at byte address 0 of the APB port and resets to 4412.
// Reset empties the pipeline; it must be written only while no beat is in
// flight.
// ----------------------------------------------------------------------------
module sample_trim_nudge_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fine, total_bytes, rate_hz, align_bytes, start_in, size_in, end_in, zero pad
  input  logic [stn_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // start_out, size_out, end_out
  output logic [stn_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [stn_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [stn_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [stn_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import stn_pkg::*;

  localparam int FINE_LSB  = 0;
  localparam int TOTAL_LSB = FINE_LSB + FINE_W;
  localparam int RATE_LSB  = TOTAL_LSB + FIELD_W;
  localparam int ALIGN_LSB = RATE_LSB + RATE_W;
  localparam int START_LSB = ALIGN_LSB + ALIGN_W;
  localparam int SIZE_LSB  = START_LSB + FIELD_W;
  localparam int END_LSB   = SIZE_LSB + FIELD_W;

  item_t   item;
  nudge_t  nudge;
  trim_t   trim;
  result_t res;
  logic    f_valid, f_ready, c_valid, c_ready;
  logic    cfg_wr;
  logic    reg_sel;
  logic [MIN_W-1:0] min_trim_r, min_trim_nxt;

  assign item.mode        = in_tuser;
  assign item.fine        = in_tdata[FINE_LSB +: FINE_W];
  assign item.total_bytes = BC_W'(in_tdata[TOTAL_LSB +: FIELD_W]);
  assign item.rate_hz     = in_tdata[RATE_LSB +: RATE_W];
  assign item.align_bytes = in_tdata[ALIGN_LSB +: ALIGN_W];
  assign item.start_in    = BC_W'(in_tdata[START_LSB +: FIELD_W]);
  assign item.size_in     = BC_W'(in_tdata[SIZE_LSB +: FIELD_W]);
  assign item.end_in      = BC_W'(in_tdata[END_LSB +: FIELD_W]);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    min_trim_nxt = min_trim_r;
    if (cfg_wr && reg_sel == REG_MIN_TRIM) min_trim_nxt = cfg_pwdata[MIN_W-1:0];
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_TRIM: cfg_prdata = CFG_DATA_W'(min_trim_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_trim_r <= RESET_MIN_TRIM;
    end else begin
      min_trim_r <= min_trim_nxt;
    end
  end

  stn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (nudge)
  );

  stn_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_trim  (min_trim_r),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (nudge),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (trim)
  );

  stn_align u_align (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_item   (trim),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  assign out_tdata = {res.end_out, res.size_out, res.start_out};

endmodule

FILE: src/stn_checker.sv
// ----------------------------------------------------------------------------
// Sample trim nudge checker
// Port-level properties of the trim nudge core, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_trim_nudge_core_defines.svh"

module stn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [stn_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                               cfg_psel,
  input logic                               cfg_penable,
  input logic                               cfg_pwrite,
  input logic                               cfg_pready,
  input logic [stn_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input logic [stn_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input logic [stn_pkg::CFG_DATA_W-1:0]     cfg_prdata
);
  import stn_pkg::*;

  `STN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "Stalled output beat changed or dropped")

  `STN_ASSERT_NOW(a_in_open, out_tready || !out_tvalid, in_tready,
    "Input blocked although the output side can move")

  `STN_ASSERT_NOW(a_latency, $rose(out_tvalid), $past(in_tvalid && in_tready, LATENCY),
    "Output beat appeared without an input beat one latency earlier")

  `STN_ASSERT_NOW(a_cfg_readback,
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_MIN_TRIM)
      ##1 (cfg_paddr[2] == REG_MIN_TRIM),
    cfg_prdata == CFG_DATA_W'($past(cfg_pwdata[MIN_W-1:0])),
    "Minimum trim register does not read back the written value")

endmodule

bind sample_trim_nudge_core stn_checker u_stn_checker (.*);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Sample trim nudge core testbench
// Streams directed and random nudges through the core with random stalls on
// both stream sides, bar the last two phases. The start, size and end of
// every output beat are checked against a behavioral model of the nudge.
// The minimum trim size register is written and read back between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 130;
  localparam int NUM_SEGS    = 6;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  item_t       nudge_q[$];
  item_t       nudge_on_bus;
  result_t     window_q[$];
  result_t     got_win;
  result_t     want_win;
  logic [15:0] min_trim_cfg;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          errors;
  int          stall_cycles;

  sample_trim_nudge_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t predict_window(item_t it, logic [15:0] min_trim);
    logic [63:0] total, rate, align, start_v, size_v, end_v, mag, frame_rate;
    logic [63:0] step, delta, min_v;
    logic        neg, shrink;
    result_t     r;
    total      = 64'(it.total_bytes);
    rate       = 64'(it.rate_hz);
    align      = (it.align_bytes == '0) ? 64'd1 : 64'(it.align_bytes);
    start_v    = 64'(it.start_in);
    size_v     = 64'(it.size_in);
    end_v      = 64'(it.end_in);
    min_v      = 64'(min_trim);
    neg        = it.fine[FINE_W-1];
    mag        = neg ? (64'h2000 - 64'(it.fine)) : 64'(it.fine);
    frame_rate = rate * align;
    if (total > frame_rate) begin
      step = frame_rate >> RATE_STEP_SHIFT;
    end else if (total >= 64'(LARGE_SAMPLE)) begin
      step = total >> SIZE_STEP_SHIFT;
    end else begin
      step = 64'd1;
    end
    delta  = step * mag * mag;
    shrink = neg && (delta != 0);
    if (it.mode == MODE_START) begin
      if (shrink) begin
        start_v = (start_v > delta) ? start_v - delta : 64'd0;
      end else begin
        start_v = start_v + delta;
      end
      if (start_v > end_v) begin
        start_v = end_v;
      end
      start_v = start_v - (start_v % align);
    end else begin
      if (shrink) begin
        size_v = (size_v > delta + min_v) ? size_v - delta : min_v;
      end else begin
        size_v = size_v + delta;
      end
      if (size_v > total) begin
        size_v = total;
      end
      size_v = size_v - (size_v % align);
    end
    end_v = (start_v + size_v > total) ? total : start_v + size_v;
    end_v = end_v - (end_v % align);
    r.start_out = start_v[31:0];
    r.size_out  = size_v[31:0];
    r.end_out   = end_v[31:0];
    return r;
  endfunction

  function automatic item_t make_nudge(logic mode, int fine, logic [31:0] total,
                                       logic [31:0] rate, logic [3:0] align,
                                       logic [31:0] start_v, logic [31:0] size_v,
                                       logic [31:0] end_v);
    item_t it;
    it.mode        = mode;
    it.fine        = FINE_W'(fine);
    it.total_bytes = total;
    it.rate_hz     = RATE_W'(rate);
    it.align_bytes = align;
    it.start_in    = start_v;
    it.size_in     = size_v;
    it.end_in      = end_v;
    return it;
  endfunction

  function automatic item_t random_nudge();
    item_t       it;
    logic [63:0] frame_rate;
    logic [31:0] total, rate, start_v, end_v, size_v;
    logic [3:0]  align;
    int          mag;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.mode        = 1'($urandom);
      it.fine        = FINE_W'($urandom);
      it.total_bytes = BC_W'($urandom);
      it.rate_hz     = RATE_W'($urandom);
      it.align_bytes = ALIGN_W'($urandom);
      it.start_in    = BC_W'($urandom);
      it.size_in     = BC_W'($urandom);
      it.end_in      = BC_W'($urandom);
      return it;
    end
    align = 4'($urandom_range(8, 1));
    case ($urandom_range(7))
      0: rate = 8000;
      1: rate = 11025;
      2: rate = 22050;
      3: rate = 44100;
      4: rate = 48000;
      5: rate = 96000;
      6: rate = 192000;
      default: rate = $urandom_range(192000, 1);
    endcase
    frame_rate = 64'(rate) * 64'(align);
    case ($urandom_range(2))
      0: total = $urandom_range(32767, 0);
      1: begin
        if (frame_rate >= 64'd32768) begin
          total = $urandom_range(32'(frame_rate), 32768);
        end else begin
          total = $urandom_range(32'd1 << 24, 32'(frame_rate) + 1);
        end
      end
      default: begin
        if ($urandom_range(1) == 0) begin
          total = $urandom_range(32'd1 << 26, 32'(frame_rate) + 1);
        end else begin
          total = $urandom_range(32'hFFFF_FFFF, 32'(frame_rate) + 1);
        end
      end
    endcase
    start_v = $urandom_range(total, 0);
    end_v   = $urandom_range(total, start_v);
    size_v  = end_v - start_v;
    if ($urandom_range(4) == 0) begin
      size_v = $urandom_range(32'(min_trim_cfg) + 64, 0);
    end
    if ($urandom_range(1) == 0) begin
      mag = $urandom_range(64, 0);
    end else begin
      mag = $urandom_range(4095, 0);
    end
    if ($urandom_range(1) == 0) begin
      mag = -mag;
    end
    return make_nudge(1'($urandom), mag, total, rate, align, start_v, size_v, end_v);
  endfunction

  // Input driver: a beat is held until accepted, then the next one is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        window_q.push_back(predict_window(nudge_on_bus, min_trim_cfg));
      end
      if (!in_tvalid || in_tready) begin
        if (nudge_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nudge_on_bus = nudge_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nudge_on_bus.mode;
          in_tdata  <= IN_TDATA_W'({nudge_on_bus.end_in, nudge_on_bus.size_in,
                                    nudge_on_bus.start_in, nudge_on_bus.align_bytes,
                                    nudge_on_bus.rate_hz, nudge_on_bus.total_bytes,
                                    nudge_on_bus.fine});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_win = out_tdata;
        if (window_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected output beat %h", out_tdata);
          end
        end else begin
          want_win = window_q.pop_front();
          if (got_win.start_out !== want_win.start_out ||
              got_win.size_out !== want_win.size_out ||
              got_win.end_out !== want_win.end_out) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: start %h/%h size %h/%h end %h/%h (expected/actual)",
                       want_win.start_out, got_win.start_out,
                       want_win.size_out, got_win.size_out,
                       want_win.end_out, got_win.end_out);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_min_trim(input logic [15:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * REG_MIN_TRIM);
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    min_trim_cfg = value;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== 32'(value)) begin
      errors++;
      if (errors <= 10) begin
        $display("min_trim_size readback: expected %h, actual %h", value, cfg_prdata);
      end
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (nudge_q.size() != 0 || in_tvalid || window_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] seg_min[NUM_SEGS];
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    errors       = 0;
    stall_cycles = 0;
    min_trim_cfg = RESET_MIN_TRIM;
    send_idle_pct = 38;
    recv_idle_pct = 72;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats, run with the reset value of the minimum trim size.
    nudge_q.push_back(make_nudge(MODE_START, 0, 100000, 44100, 2, 1000, 2000, 3000));
    nudge_q.push_back(make_nudge(MODE_SIZE, 0, 100000, 44100, 2, 1000, 100, 1100));
    nudge_q.push_back(make_nudge(MODE_START, 4095, 32'hFFFF_FFFF, 192000, 8, 0, 1000,
                                 32'hFFFF_FFFF));
    nudge_q.push_back(make_nudge(MODE_START, -4095, 32'hFFFF_FFFF, 192000, 8, 10,
                                 1000, 2000));
    nudge_q.push_back(make_nudge(MODE_SIZE, 4095, 32'hFFFF_FFFF, 192000, 8,
                                 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    nudge_q.push_back(make_nudge(MODE_SIZE, -4095, 32'hFFFF_FFFF, 192000, 8, 0,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    nudge_q.push_back(make_nudge(MODE_START, -4096, 5000000, 48000, 4, 4000000,
                                 100000, 4100000));
    nudge_q.push_back(make_nudge(MODE_SIZE, -4096, 5000000, 48000, 4, 0, 4000000,
                                 4000000));
    nudge_q.push_back(make_nudge(MODE_START, 3, 0, 44100, 2, 0, 0, 0));
    nudge_q.push_back(make_nudge(MODE_SIZE, 3, 0, 44100, 2, 0, 0, 0));
    nudge_q.push_back(make_nudge(MODE_START, 20, 70000, 0, 2, 100, 200, 300));
    nudge_q.push_back(make_nudge(MODE_SIZE, -20, 1000000, 32'h3FFFF, 15, 100, 90000,
                                 90100));
    nudge_q.push_back(make_nudge(MODE_START, 7, 1000000, 44100, 0, 333, 5555, 5888));
    nudge_q.push_back(make_nudge(MODE_SIZE, 7, 1000000, 44100, 9, 333, 5555, 5888));
    nudge_q.push_back(make_nudge(MODE_SIZE, -5, 100000, 1000, 2, 10, 3000, 3010));
    nudge_q.push_back(make_nudge(MODE_START, 0, 100000, 44100, 2, 9000, 10, 500));
    nudge_q.push_back(make_nudge(MODE_START, -4095, 20000, 44100, 2, 10, 100, 110));
    nudge_q.push_back(make_nudge(MODE_SIZE, -3, 20000, 44100, 2, 10, 5000, 5010));
    nudge_q.push_back(make_nudge(MODE_SIZE, -1, 20000, 44100, 2, 10, 10000, 10010));
    nudge_q.push_back(make_nudge(MODE_START, 100, 60000, 44100, 2, 100, 5000, 5100));
    nudge_q.push_back(make_nudge(MODE_SIZE, 50, 20000, 44100, 2, 100, 100, 200));
    nudge_q.push_back(make_nudge(MODE_START, 4095, 20000, 1, 1, 19000, 500, 19999));
    wait_drained();

    seg_min[0] = 16'd0;
    seg_min[1] = 16'hFFFF;
    seg_min[2] = 16'($urandom_range(65535, 0));
    seg_min[3] = 16'd1;
    seg_min[4] = 16'($urandom_range(65535, 0));
    seg_min[5] = RESET_MIN_TRIM;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 72;
      end else if (seg < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_min_trim(seg_min[seg]);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        nudge_q.push_back(random_nudge());
      end
      wait_drained();
    end

    if (errors == 0 && window_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/stn_pkg.sv
src/stn_front.sv
src/stn_clamp.sv
src/stn_align.sv
src/sample_trim_nudge_core.sv
src/stn_checker.sv
test/tb_top.sv
